// ===== rtl/core/tlli_pkg.sv =====
package tlli_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] EntriesReset = 5'd16;

  typedef enum logic [1:0] {
    CmdWrBp  = 2'd0,
    CmdWrVal = 2'd1,
    CmdLookup = 2'd2,
    CmdStore = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StInterp = 3'd0,
    StLow    = 3'd1,
    StHigh   = 3'd2,
    StEqual  = 3'd3,
    StWrite  = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic rd_mid;     // read tables at mid
    logic step;       // apply probe compare to bounds
    logic rd_pair;    // read entry i and i+1 (first word)
    logic rd_pair2;   // second word of pair
    logic mul_step;
    logic div_init;
    logic div_step;
    logic finish;     // form result into output register
    logic do_write;   // perform table write
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic below;
    logic search_done;
    logic mul_done;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/core/table_lookup_linear_interp.sv =====
// 1-D lookup table with linear interpolation, signed Q16.16.
// Input channel: in_valid_i/in_ready_o with cmd_i, entry_index_i, key_i,
// data_value_i. Output channel: out_valid_o/out_ready_i with
// result_value_o and status_o; one result per input transfer.
// cmd 0/1 write a breakpoint/value, 2 looks up key_i, 3 stores data_value_i
// at the entry the key selects.
// entries_in_use is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, the block does not enforce this. A key store
// and a lookup make P bisection probes (up to log2(depth)+2), each a read of
// the one-port table; a lookup then runs the bit-serial divider.
// One item is in flight at a time; the next transfer is taken in the
// cycle the result is taken.
// Reset clears the controller and sets entries_in_use to 16; the tables
// hold no reset value and must be written before use.
// If the receiver stalls, the result is held and no input is accepted.
module table_lookup_linear_interp #(
  parameter int unsigned TableDepth = tlli_pkg::TableDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] data_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [2:0]         status_o
);

  logic [4:0] entries_q;
  tlli_pkg::ctrl_t ctrl;
  tlli_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) entries_q <= tlli_pkg::EntriesReset;
    else if (cfg_we_i) entries_q <= cfg_wdata_i;
  end

  tlli_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_i, .stat_i(stat), .ctrl_o(ctrl)
  );

  tlli_dp #(.TableDepth(TableDepth)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .entries_q_i(entries_q),
    .cmd_i, .entry_index_i, .key_i, .data_value_i, .result_value_o, .status_o
  );

endmodule

// ===== rtl/core/tlli_ctrl.sv =====
module tlli_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic [1:0]       cmd_i,
  input  tlli_pkg::stat_t  stat_i,
  output tlli_pkg::ctrl_t  ctrl_o
);

  typedef enum logic [9:0] {
    SIdle  = 10'b0000000001,
    SProbe = 10'b0000000010,
    SCmp   = 10'b0000000100,
    SPairA = 10'b0000001000,
    SPairB = 10'b0000010000,
    SMul   = 10'b0000100000,
    SDiv   = 10'b0001000000,
    SFin   = 10'b0010000000,
    SWr    = 10'b0100000000,
    SOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cmd_q <= tlli_pkg::CmdWrBp;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) cmd_q <= cmd_i;
    end
  end

  assign in_ready_o = (state_q == SIdle) || ((state_q == SOut) && out_ready_i);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    ctrl_o.load = in_valid_i && in_ready_o;
    case (state_q)
      SIdle, SOut: begin
        if (state_q == SOut && out_ready_i) state_d = SIdle;
        if (in_valid_i && in_ready_o) begin
          if (cmd_i == tlli_pkg::CmdWrBp || cmd_i == tlli_pkg::CmdWrVal) state_d = SWr;
          else state_d = SProbe;
        end
      end
      SProbe: begin
        ctrl_o.rd_mid = 1'b1;
        state_d = SCmp;
      end
      SCmp: begin
        if (stat_i.below || stat_i.search_done) begin
          if (cmd_q == tlli_pkg::CmdStore) state_d = SWr;
          else state_d = SPairA;
        end else begin
          ctrl_o.step = 1'b1;
          state_d = SProbe;
        end
      end
      SPairA: begin
        ctrl_o.rd_pair = 1'b1;
        state_d = SPairB;
      end
      SPairB: begin
        ctrl_o.rd_pair2 = 1'b1;
        state_d = SMul;
      end
      SMul: begin
        ctrl_o.mul_step = 1'b1;
        if (stat_i.mul_done) begin
          ctrl_o.mul_step = 1'b0;
          ctrl_o.div_init = 1'b1;
          state_d = SDiv;
        end
      end
      SDiv: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = SFin;
      end
      SFin: begin
        ctrl_o.finish = 1'b1;
        state_d = SOut;
      end
      SWr: begin
        ctrl_o.do_write = 1'b1;
        state_d = SOut;
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

// ===== rtl/core/tlli_dp.sv =====
module tlli_dp #(
  parameter int unsigned TableDepth = tlli_pkg::TableDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlli_pkg::ctrl_t               ctrl_i,
  output tlli_pkg::stat_t               stat_o,
  input  logic [tlli_pkg::CountW-1:0]   entries_q_i,
  input  logic [1:0]                    cmd_i,
  input  logic [3:0]                    entry_index_i,
  input  logic signed [31:0]            key_i,
  input  logic signed [31:0]            data_value_i,
  output logic signed [31:0]            result_value_o,
  output logic [2:0]                    status_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned NW = $clog2(TableDepth + 1);

  logic signed [31:0] bp_mem [TableDepth];
  logic signed [31:0] val_mem [TableDepth];

  logic [1:0] cmd_q;
  logic [3:0] widx_q;
  logic signed [31:0] key_q, data_q;
  logic [NW-1:0] n_q, left_q, right_q, mid;
  logic [NW:0] sum;
  logic first_q;
  logic signed [31:0] rbp_q, rval_q;
  logic signed [31:0] x1_q, y1_q, x2_q;
  logic rsel_q;
  logic [NW-1:0] idx_q;
  logic below_hold_q;

  // effective count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (entries_q_i < 5'd2) n_eff = NW'(2);
    else if ({27'd0, entries_q_i} > 32'(TableDepth)) n_eff = NW'(TableDepth);
    else n_eff = NW'(entries_q_i);
  end

  assign sum = {1'b0, left_q} + {1'b0, right_q};
  assign mid = sum[NW:1];

  // probe address
  logic [IdxW-1:0] raddr;
  always_comb begin
    if (first_q) raddr = '0;
    else if (rsel_q) raddr = IdxW'(idx_q + NW'(1));
    else if (ctrl_i.rd_mid) raddr = IdxW'(mid);
    else raddr = IdxW'(idx_q);
  end

  always_ff @(posedge clk_i) begin
    rbp_q <= bp_mem[raddr];
    rval_q <= val_mem[raddr];
    if (ctrl_i.do_write) begin
      if (cmd_q == tlli_pkg::CmdWrBp && 32'(widx_q) < 32'(TableDepth))
        bp_mem[IdxW'(widx_q)] <= data_q;
      else if (cmd_q == tlli_pkg::CmdWrVal && 32'(widx_q) < 32'(TableDepth))
        val_mem[IdxW'(widx_q)] <= data_q;
      else if (cmd_q == tlli_pkg::CmdStore)
        val_mem[below_hold_q ? IdxW'(0) : IdxW'(idx_q)] <= data_q;
    end
  end

  // search
  logic k_lt, k_gt;
  assign k_lt = key_q < rbp_q;
  assign k_gt = key_q > rbp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
      rsel_q <= 1'b0;
    end else begin
      if (ctrl_i.load) first_q <= 1'b1;
      else if (ctrl_i.rd_mid) first_q <= 1'b0;
      rsel_q <= ctrl_i.rd_pair;
    end
  end

  // compare stage: SCmp sees rbp_q from probe
  logic probe0_q;
  logic [NW-1:0] pmid_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      widx_q <= entry_index_i;
      key_q <= key_i;
      data_q <= data_value_i;
      n_q <= n_eff;
      left_q <= '0;
      right_q <= n_eff;
    end
    if (ctrl_i.rd_mid) begin
      probe0_q <= first_q;
      pmid_q <= mid;
    end
    if (ctrl_i.step && !probe0_q) begin
      if (k_lt) right_q <= pmid_q;
      else left_q <= pmid_q;
    end
  end

  // status of current compare
  logic stop_now;
  always_comb begin
    stop_now = 1'b0;
    if (!probe0_q) begin
      if (pmid_q == left_q) stop_now = 1'b1;
      else if (!k_lt && !k_gt) stop_now = 1'b1;
    end
  end
  assign stat_o.below = probe0_q && k_lt;
  assign stat_o.search_done = stop_now;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step || stop_now) idx_q <= pmid_q;
    else if (probe0_q && k_lt) idx_q <= '0;
  end
  // mark below for later stages
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) below_hold_q <= 1'b0;
    else if (probe0_q && k_lt && !ctrl_i.rd_mid && !ctrl_i.rd_pair) below_hold_q <= 1'b1;
  end

  // pair capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_pair2) begin
      x1_q <= rbp_q;
      y1_q <= rval_q;
    end
  end
  logic pair2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pair2_q <= 1'b0;
    else pair2_q <= ctrl_i.rd_pair2;
  end
  always_ff @(posedge clk_i) begin
    if (pair2_q) x2_q <= rbp_q;
  end

  // multiply 33x33 magnitudes in two 33x17 halves
  // first multiply cycle: rbp_q/rval_q still hold entry i+1
  logic [32:0] mdy_q, mdk_q, mdx_q;
  logic neg_q;
  logic [65:0] prod_q;
  logic [1:0] mcnt_q;
  logic signed [32:0] dy, dk, dx;
  assign dy = 33'(rval_q) - 33'(y1_q);
  assign dk = 33'(key_q) - 33'(x1_q);
  assign dx = 33'(rbp_q) - 33'(x1_q);
  logic [16:0] mpart;
  assign mpart = (mcnt_q == 2'd1) ? {1'b0, mdk_q[15:0]} : mdk_q[32:16];
  logic [49:0] pp;
  assign pp = mdy_q * mpart;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mcnt_q <= 2'd0;
    else if (ctrl_i.div_init) mcnt_q <= 2'd0;
    else if (ctrl_i.mul_step) mcnt_q <= mcnt_q + 2'd1;
  end
  assign stat_o.mul_done = (mcnt_q == 2'd3);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_step && mcnt_q == 2'd0) begin
      mdy_q <= dy[32] ? 33'(-dy) : 33'(dy);
      mdk_q <= dk[32] ? 33'(-dk) : 33'(dk);
      mdx_q <= dx[32] ? 33'(-dx) : 33'(dx);
      neg_q <= (dy[32] ^ dk[32]) ^ dx[32];
      prod_q <= '0;
    end else if (ctrl_i.mul_step && mcnt_q == 2'd1) begin
      prod_q <= 66'(pp);
    end else if (ctrl_i.mul_step && mcnt_q == 2'd2) begin
      prod_q <= prod_q + {pp[49:0], 16'd0};
    end
  end

  // restoring divide, 66 steps
  logic [65:0] dq_q;
  logic [33:0] rem_q;
  logic [6:0] dcnt_q;
  logic big_q;
  logic [33:0] rsh, rsub;
  assign rsh = {rem_q[32:0], dq_q[65]};
  assign rsub = rsh - {1'b0, mdx_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dcnt_q <= '0;
    else if (ctrl_i.div_init) dcnt_q <= 7'd66;
    else if (ctrl_i.div_step && dcnt_q != 7'd0) dcnt_q <= dcnt_q - 7'd1;
  end
  assign stat_o.div_done = ctrl_i.div_step && (dcnt_q == 7'd1);
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_init) begin
      dq_q <= prod_q;
      rem_q <= '0;
      big_q <= 1'b0;
    end else if (ctrl_i.div_step && dcnt_q != 7'd0) begin
      if (!rsub[33]) begin
        rem_q <= rsub;
        dq_q <= {dq_q[64:0], 1'b1};
        if (dcnt_q > 7'd40) big_q <= 1'b1;
      end else begin
        rem_q <= rsh;
        dq_q <= {dq_q[64:0], 1'b0};
      end
    end
  end

  // result
  logic signed [41:0] q42, s42;
  assign q42 = {2'b00, dq_q[39:0]};
  assign s42 = neg_q ? (42'(y1_q) - q42) : (42'(y1_q) + q42);
  localparam logic signed [31:0] Max = 32'sh7fffffff;
  localparam logic signed [31:0] Min = 32'sh80000000;

  logic lastp;
  assign lastp = (idx_q == n_q - NW'(1));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_write) begin
      result_value_o <= '0;
      status_o <= tlli_pkg::StWrite;
    end else if (ctrl_i.finish) begin
      if (below_hold_q) begin
        result_value_o <= y1_q;
        status_o <= tlli_pkg::StLow;
      end else if (lastp) begin
        result_value_o <= y1_q;
        status_o <= tlli_pkg::StHigh;
      end else if (x1_q == x2_q) begin
        result_value_o <= '0;
        status_o <= tlli_pkg::StEqual;
      end else begin
        status_o <= tlli_pkg::StInterp;
        if (big_q) result_value_o <= neg_q ? Min : Max;
        else if (s42 > 42'(Max)) result_value_o <= Max;
        else if (s42 < 42'(Min)) result_value_o <= Min;
        else result_value_o <= s42[31:0];
      end
    end
  end

endmodule

// ===== rtl/core/tlli_checker.sv =====
module tlli_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= tlli_pkg::StWrite) else $error("bad status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("output dropped");

  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o) else $error("accept while stalled");

  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o) else $error("early result");

endmodule

bind table_lookup_linear_interp tlli_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .status_o
);

// ===== test/table_lookup_linear_interp_test.sv =====
`timescale 1ns / 100ps

module table_lookup_linear_interp_test;

  typedef struct {
    logic signed [31:0]  value;
    tlli_pkg::status_e   st;
  } lookup_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [4:0]         cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         cmd_i = '0;
  logic [3:0]         entry_index_i = '0;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] data_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [2:0]         status_o;

  table_lookup_linear_interp dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .cmd_i, .entry_index_i, .key_i, .data_value_i, .out_valid_o, .out_ready_i,
    .result_value_o, .status_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic signed [31:0] bp_tab [16];
  logic signed [31:0] val_tab [16];
  logic [4:0]         entries_cfg = tlli_pkg::EntriesReset;
  lookup_result_t     pending_results [$];
  bit                 idle_en = 1'b1;
  int                 errors = 0;
  int                 items_sent = 0;
  int                 checked = 0;
  int                 status_seen [5];
  int                 stall_cnt = 0;

  function automatic int used_entries();
    if (entries_cfg < 2) return 2;
    if (entries_cfg > 16) return 16;
    return entries_cfg;
  endfunction

  function automatic int find_segment(logic signed [31:0] k, int n);
    int lo, hi, mid;
    lo = 0;
    hi = n;
    if (k < bp_tab[0]) return -1;
    forever begin
      mid = (lo + hi) / 2;
      if (mid == lo) break;
      if (k < bp_tab[mid]) hi = mid;
      else if (k > bp_tab[mid]) lo = mid;
      else break;
    end
    return mid;
  endfunction

  function automatic logic signed [31:0] interp_q16(int i, logic signed [31:0] k);
    longint dy, dk, dx, s;
    logic [127:0] prod, q;
    logic [63:0] mdy, mdk, mdx;
    bit neg;
    dy = longint'(val_tab[i+1]) - longint'(val_tab[i]);
    dk = longint'(k) - longint'(bp_tab[i]);
    dx = longint'(bp_tab[i+1]) - longint'(bp_tab[i]);
    neg = ((dy < 0) != (dk < 0)) != (dx < 0);
    mdy = dy < 0 ? -dy : dy;
    mdk = dk < 0 ? -dk : dk;
    mdx = dx < 0 ? -dx : dx;
    prod = {64'd0, mdy} * {64'd0, mdk};
    q = prod / {64'd0, mdx};
    if (q >= (128'd1 << 40)) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    s = neg ? longint'(val_tab[i]) - longint'(q[63:0])
            : longint'(val_tab[i]) + longint'(q[63:0]);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic lookup_result_t table_response(tlli_pkg::cmd_e c, logic [3:0] idx,
                                                    logic signed [31:0] k,
                                                    logic signed [31:0] d);
    lookup_result_t r;
    int n, i;
    n = used_entries();
    r.value = '0;
    r.st = tlli_pkg::StWrite;
    case (c)
      tlli_pkg::CmdWrBp:  bp_tab[idx] = d;
      tlli_pkg::CmdWrVal: val_tab[idx] = d;
      tlli_pkg::CmdStore: begin
        i = find_segment(k, n);
        val_tab[i < 0 ? 0 : i] = d;
      end
      default: begin
        i = find_segment(k, n);
        if (i < 0) begin
          r.value = val_tab[0];
          r.st = tlli_pkg::StLow;
        end else if (i == n - 1) begin
          r.value = val_tab[n-1];
          r.st = tlli_pkg::StHigh;
        end else if (bp_tab[i] == bp_tab[i+1]) begin
          r.st = tlli_pkg::StEqual;
        end else begin
          r.value = interp_q16(i, k);
          r.st = tlli_pkg::StInterp;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(tlli_pkg::cmd_e c, logic [3:0] idx, logic signed [31:0] k,
                           logic signed [31:0] d);
    lookup_result_t r;
    r = table_response(c, idx, k, d);
    pending_results.push_back(r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    entry_index_i <= idx;
    key_i <= k;
    data_value_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic set_entries(logic [4:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    entries_cfg = v;
  endtask

  // output side: random stall bursts
  always @(posedge clk_i) begin
    if (stall_cnt > 0) begin
      out_ready_i <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_cnt <= $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    lookup_result_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: value %h status %0d",
               result_value_o, status_o);
        errors++;
      end else begin
        r = pending_results.pop_front();
        checked++;
        status_seen[r.st]++;
        if (result_value_o !== r.value) begin
          $error("result_value: expected %h actual %h", r.value, result_value_o);
          errors++;
        end
        if (status_o !== r.st) begin
          $error("status: expected %0d actual %0d", r.st, status_o);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [31:0] near_key();
    int j;
    longint span;
    j = $urandom_range(0, 15);
    span = (j < 15) ? longint'(bp_tab[j+1]) - longint'(bp_tab[j]) : 64'sd65535;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return bp_tab[j];
      2: return bp_tab[j] - 32'sd1;
      3: return bp_tab[j] + 32'sd1;
      default: return 32'(longint'(bp_tab[j])
                          + span * longint'($urandom_range(0, 1000)) / 1000);
    endcase
  endfunction

  task automatic load_table(bit ascending);
    int vals [16];
    foreach (vals[i]) begin
      case ($urandom_range(0, 3))
        0: vals[i] = $urandom;
        1: vals[i] = int'($urandom_range(0, 65535)) - 32768;
        default: vals[i] = int'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      endcase
    end
    if (ascending) vals.sort();
    if ($urandom_range(0, 2) == 0) vals[$urandom_range(1, 15)] = vals[0] + 0;
    if (ascending) vals.sort();
    for (int i = 0; i < 16; i++) send_item(tlli_pkg::CmdWrBp, i[3:0], $urandom, vals[i]);
    for (int i = 0; i < 16; i++) send_item(tlli_pkg::CmdWrVal, i[3:0], $urandom, $urandom);
  endtask

  task automatic test_directed();
    for (int i = 0; i < 16; i++)
      send_item(tlli_pkg::CmdWrBp, i[3:0], '0, (i - 8) * 32'sh0001_0000);
    for (int i = 0; i < 16; i++)
      send_item(tlli_pkg::CmdWrVal, i[3:0], '0, i * 32'sh0000_4000 - 32'sh0002_0000);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh8000_0000, '0);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh7fff_ffff, '0);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh0000_8000, '0);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh0007_0000, '0);
    send_item(tlli_pkg::CmdLookup, 4'd0, -32'sh0008_0000, '0);
    send_item(tlli_pkg::CmdStore, 4'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_item(tlli_pkg::CmdStore, 4'd0, 32'sh0000_1234, 32'sh8000_0000);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh0000_1000, '0);
    send_item(tlli_pkg::CmdLookup, 4'd0, -32'sh0009_0000, '0);
    // duplicated neighbor breakpoints
    send_item(tlli_pkg::CmdWrBp, 4'd9, '0, 32'sh0000_0000);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh0000_0000, '0);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh0000_0001, '0);
    // rising pair with huge slope
    send_item(tlli_pkg::CmdWrBp, 4'd9, '0, 32'sh0000_0001);
    send_item(tlli_pkg::CmdWrVal, 4'd9, '0, 32'sh7fff_ffff);
    send_item(tlli_pkg::CmdWrVal, 4'd8, '0, 32'sh8000_0000);
    send_item(tlli_pkg::CmdLookup, 4'd0, 32'sh0000_0000, '0);
    send_item(tlli_pkg::CmdWrBp, 4'd15, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(tlli_pkg::CmdWrBp, 4'd0, 32'sh7fff_ffff, 32'sh8000_0000);
    send_item(tlli_pkg::CmdLookup, 4'hf, 32'sh7fff_fffe, 32'sh7fff_ffff);
  endtask

  task automatic test_entry_counts();
    logic [4:0] counts [6] = '{5'd2, 5'd0, 5'd1, 5'd31, 5'd17, 5'd16};
    foreach (counts[c]) begin
      set_entries(counts[c]);
      for (int i = 0; i < 4; i++) send_item(tlli_pkg::CmdLookup, '0, near_key(), '0);
      send_item(tlli_pkg::CmdStore, '0, near_key(), $urandom);
    end
  endtask

  task automatic test_random(int phases, int per_phase);
    int r;
    for (int p = 0; p < phases; p++) begin
      if ($urandom_range(0, 4) == 0) set_entries(5'($urandom));
      else set_entries(5'($urandom_range(2, 16)));
      load_table($urandom_range(0, 7) != 0);
      for (int i = 0; i < per_phase; i++) begin
        r = $urandom_range(0, 19);
        if (r < 14)
          send_item(tlli_pkg::CmdLookup, 4'($urandom), near_key(), $urandom);
        else if (r < 16)
          send_item(tlli_pkg::CmdStore, 4'($urandom), near_key(), $urandom);
        else if (r < 18)
          send_item(tlli_pkg::CmdWrVal, 4'($urandom), $urandom, $urandom);
        else
          send_item(tlli_pkg::CmdWrBp, 4'($urandom), $urandom, $urandom);
        if (i == per_phase / 2 && p == 0) drain();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_entry_counts();
    test_random(6, 250);
    idle_en = 1'b0;
    test_random(2, 200);
    drain();
    $display("Sent %0d transfers, checked %0d results (interp %0d, low %0d, high %0d,",
             items_sent, checked, status_seen[0], status_seen[1], status_seen[2]);
    $display("equal %0d, write %0d) over several entry counts and table shapes.",
             status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
